// ===== rtl/text_console_cursor_scroll_defines.svh =====
// assertion macros for the console checker
`ifndef TEXT_CONSOLE_CURSOR_SCROLL_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_SCROLL_DEFINES_SVH

// same-cycle implication
`define CTS_ASSERT_IMP(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication
`define CTS_ASSERT_NXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== rtl/cts_pkg.sv =====
package cts_pkg;

    localparam int SCREEN_WIDTH  = 80;
    localparam int SCREEN_HEIGHT = 25;
    localparam int CELL_COUNT    = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int ADDR_W        = $clog2(CELL_COUNT);
    localparam int PTR_W         = $clog2(CELL_COUNT + 1);

    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_RETURN  = 8'd13;

    typedef enum logic [1:0] {
        ACT_PUT   = 2'd0,
        ACT_SET   = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_READ  = 2'd3
    } action_t;

    typedef struct packed {
        action_t    action;
        logic [7:0] char_code;
        logic [3:0] color;
        logic       use_default_color;
        logic [6:0] column;
        logic [4:0] row;
    } req_t;

    typedef struct packed {
        logic [15:0] cell_value;
        logic [6:0]  cursor_column;
        logic [4:0]  cursor_row;
        logic        scrolled;
    } res_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [15:0]       wdata;
    } ram_wr_t;

    typedef struct packed {
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } ram_rd_t;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [4:0] line,
                                                    input logic [6:0] col);
        cell_addr = ADDR_W'(line) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(col);
    endfunction

endpackage

// ===== rtl/cts_cell_ram.sv =====
module cts_cell_ram
    import cts_pkg::*;
(
    input  logic        clk,
    input  ram_wr_t     wr,
    input  ram_rd_t     rd,
    output logic [15:0] rdata
);

    logic [15:0] mem [CELL_COUNT];

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.waddr] <= wr.wdata;
        end
        if (rd.re)
        begin
            rdata <= mem[rd.raddr];
        end
    end

endmodule

// ===== rtl/cts_ctrl.sv =====
module cts_ctrl
    import cts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  req_t        request,
    input  logic [3:0]  default_color,
    output logic        busy,
    output logic        done,
    output res_t        result,
    output ram_wr_t     ram_wr,
    output ram_rd_t     ram_rd,
    input  logic [15:0] ram_rdata
);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_CLEAR,
        S_READ,
        S_SCROLL,
        S_BLANK,
        S_PUT
    } state_t;

    state_t            state_reg;
    logic [PTR_W-1:0]  ptr_reg;
    logic [6:0]        cursor_col_reg;
    logic [4:0]        cursor_line_reg;
    logic [ADDR_W-1:0] put_addr_reg;
    logic [15:0]       put_data_reg;
    logic              put_pending_reg;
    logic              scrolled_reg;
    logic              in_range_reg;
    logic              copy_valid_reg;
    logic [ADDR_W-1:0] copy_addr_reg;
    logic              done_reg;
    res_t              result_reg;

    logic       is_nl;
    logic       is_cr;
    logic [6:0] pc;
    logic [4:0] pl;
    logic       scr;
    logic       wr_char;
    logic [3:0] fg;
    logic       rd_in_range;
    logic [6:0] set_col;
    logic [4:0] set_row;

    // put char cursor arithmetic, read range check and set cursor clamps
    always_comb
    begin
        is_nl   = (request.char_code == CH_NEWLINE);
        is_cr   = (request.char_code == CH_RETURN);
        pc      = cursor_col_reg;
        pl      = cursor_line_reg;
        scr     = 1'b0;
        wr_char = !(is_nl || is_cr);
        fg      = request.use_default_color ? default_color : request.color;
        if (is_nl)
        begin
            pl = pl + 5'd1;
            pc = '0;
        end
        if (is_cr)
        begin
            pc = '0;
        end
        if (pc >= 7'(SCREEN_WIDTH))
        begin
            pc = '0;
            pl = pl + 5'd1;
        end
        if (pl >= 5'(SCREEN_HEIGHT))
        begin
            pl  = 5'(SCREEN_HEIGHT - 1);
            pc  = '0;
            scr = 1'b1;
        end
        rd_in_range = (request.column < 7'(SCREEN_WIDTH)) && (request.row < 5'(SCREEN_HEIGHT));
        set_col = (request.column > 7'(SCREEN_WIDTH)) ? 7'(SCREEN_WIDTH) : request.column;
        set_row = (request.row > 5'(SCREEN_HEIGHT - 1)) ? 5'(SCREEN_HEIGHT - 1) : request.row;
    end

    // memory port selection
    always_comb
    begin
        ram_wr = '0;
        ram_rd = '0;
        unique case (state_reg)
            S_INIT, S_CLEAR, S_BLANK:
            begin
                ram_wr.we    = 1'b1;
                ram_wr.waddr = ptr_reg[ADDR_W-1:0];
            end
            S_SCROLL:
            begin
                ram_wr.we    = copy_valid_reg;
                ram_wr.waddr = copy_addr_reg;
                ram_wr.wdata = ram_rdata;
                ram_rd.re    = (ptr_reg != PTR_W'(CELL_COUNT));
                ram_rd.raddr = ptr_reg[ADDR_W-1:0];
            end
            S_PUT:
            begin
                ram_wr.we    = 1'b1;
                ram_wr.waddr = put_addr_reg;
                ram_wr.wdata = put_data_reg;
            end
            S_IDLE:
            begin
                ram_rd.re    = start && (request.action == ACT_READ) && rd_in_range;
                ram_rd.raddr = cell_addr(request.row, request.column);
            end
            S_READ:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_INIT;
            ptr_reg         <= '0;
            cursor_col_reg  <= '0;
            cursor_line_reg <= '0;
            put_addr_reg    <= '0;
            put_data_reg    <= '0;
            put_pending_reg <= 1'b0;
            scrolled_reg    <= 1'b0;
            in_range_reg    <= 1'b0;
            copy_valid_reg  <= 1'b0;
            copy_addr_reg   <= '0;
            done_reg        <= 1'b0;
            result_reg      <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_INIT, S_CLEAR:
                begin
                    ptr_reg <= ptr_reg + PTR_W'(1);
                    if (ptr_reg == PTR_W'(CELL_COUNT - 1))
                    begin
                        state_reg <= S_IDLE;
                        if (state_reg == S_CLEAR)
                        begin
                            done_reg   <= 1'b1;
                            result_reg <= '0;
                        end
                    end
                end
                S_IDLE:
                begin
                    if (start)
                    begin
                        unique case (request.action)
                            ACT_PUT:
                            begin
                                cursor_line_reg <= pl;
                                cursor_col_reg  <= wr_char ? pc + 7'd1 : pc;
                                put_addr_reg    <= cell_addr(pl, pc);
                                put_data_reg    <= {4'b0, fg, request.char_code};
                                put_pending_reg <= wr_char;
                                scrolled_reg    <= scr;
                                if (scr)
                                begin
                                    state_reg      <= S_SCROLL;
                                    ptr_reg        <= PTR_W'(SCREEN_WIDTH);
                                    copy_valid_reg <= 1'b0;
                                end
                                else if (wr_char)
                                begin
                                    state_reg <= S_PUT;
                                end
                                else
                                begin
                                    done_reg                 <= 1'b1;
                                    result_reg.cell_value    <= '0;
                                    result_reg.cursor_column <= pc;
                                    result_reg.cursor_row    <= pl;
                                    result_reg.scrolled      <= 1'b0;
                                end
                            end
                            ACT_SET:
                            begin
                                cursor_col_reg           <= set_col;
                                cursor_line_reg          <= set_row;
                                done_reg                 <= 1'b1;
                                result_reg.cell_value    <= '0;
                                result_reg.cursor_column <= set_col;
                                result_reg.cursor_row    <= set_row;
                                result_reg.scrolled      <= 1'b0;
                            end
                            ACT_CLEAR:
                            begin
                                cursor_col_reg  <= '0;
                                cursor_line_reg <= '0;
                                ptr_reg         <= '0;
                                state_reg       <= S_CLEAR;
                            end
                            ACT_READ:
                            begin
                                in_range_reg <= rd_in_range;
                                state_reg    <= S_READ;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_READ:
                begin
                    state_reg                <= S_IDLE;
                    done_reg                 <= 1'b1;
                    result_reg.cell_value    <= in_range_reg ? ram_rdata : 16'd0;
                    result_reg.cursor_column <= cursor_col_reg;
                    result_reg.cursor_row    <= cursor_line_reg;
                    result_reg.scrolled      <= 1'b0;
                end
                S_SCROLL:
                begin
                    if (ptr_reg == PTR_W'(CELL_COUNT))
                    begin
                        copy_valid_reg <= 1'b0;
                        ptr_reg        <= PTR_W'(CELL_COUNT - SCREEN_WIDTH);
                        state_reg      <= S_BLANK;
                    end
                    else
                    begin
                        copy_valid_reg <= 1'b1;
                        copy_addr_reg  <= ADDR_W'(ptr_reg - PTR_W'(SCREEN_WIDTH));
                        ptr_reg        <= ptr_reg + PTR_W'(1);
                    end
                end
                S_BLANK:
                begin
                    ptr_reg <= ptr_reg + PTR_W'(1);
                    if (ptr_reg == PTR_W'(CELL_COUNT - 1))
                    begin
                        if (put_pending_reg)
                        begin
                            state_reg <= S_PUT;
                        end
                        else
                        begin
                            state_reg                <= S_IDLE;
                            done_reg                 <= 1'b1;
                            result_reg.cell_value    <= '0;
                            result_reg.cursor_column <= cursor_col_reg;
                            result_reg.cursor_row    <= cursor_line_reg;
                            result_reg.scrolled      <= scrolled_reg;
                        end
                    end
                end
                S_PUT:
                begin
                    state_reg                <= S_IDLE;
                    done_reg                 <= 1'b1;
                    result_reg.cell_value    <= '0;
                    result_reg.cursor_column <= cursor_col_reg;
                    result_reg.cursor_row    <= cursor_line_reg;
                    result_reg.scrolled      <= scrolled_reg;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== rtl/text_console_cursor_scroll.sv =====
// channel  | signals                              | transfer
// request  | start, busy, request               | start high and busy low
// result   | done, result                       | done high, one cycle, no stall
// config   | cfg_valid, cfg_ready, cfg_data     | cfg_valid and cfg_ready high
//
// set cursor, and newline or return without scroll: done in the cycle after the request is taken
// put char and read cell: through the S_PUT or S_READ state (one cell store write or one registered read)
// clear: one cell per cycle over all 2000 cells through the shared address counter
// scroll: copy of 1920 cells then blank of the last row
// after reset busy stays high during a clearing pass over the cell store
// the receiver cannot stall; cfg_ready is always high
module text_console_cursor_scroll
    import cts_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  req_t       request,
    output logic       done,
    output res_t       result,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [3:0] cfg_data
);

    logic [3:0]  default_color_reg;
    ram_wr_t     ram_wr;
    ram_rd_t     ram_rd;
    logic [15:0] ram_rdata;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_color_reg <= 4'd7;
        end
        else if (cfg_valid && cfg_ready)
        begin
            default_color_reg <= cfg_data;
        end
    end

    cts_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .request       (request),
        .default_color (default_color_reg),
        .busy          (busy),
        .done          (done),
        .result        (result),
        .ram_wr        (ram_wr),
        .ram_rd        (ram_rd),
        .ram_rdata     (ram_rdata)
    );

    cts_cell_ram u_ram (
        .clk   (clk),
        .wr    (ram_wr),
        .rd    (ram_rd),
        .rdata (ram_rdata)
    );

endmodule

// ===== rtl/cts_checker.sv =====
`include "text_console_cursor_scroll_defines.svh"

module cts_checker
    import cts_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input req_t       request,
    input logic       done,
    input res_t       result
);

    `CTS_ASSERT_IMP(a_done_idle, clk, rst_n, done, !busy, "result while busy")

    `CTS_ASSERT_NXT(a_accept_moves, clk, rst_n, start && !busy, busy || done, "request dropped")

    `CTS_ASSERT_IMP(a_cursor_bounds, clk, rst_n, done,
        (result.cursor_column <= 7'(SCREEN_WIDTH)) &&
        (result.cursor_row <= 5'(SCREEN_HEIGHT - 1)), "cursor out of bounds")

    `CTS_ASSERT_IMP(a_scroll_row, clk, rst_n, done && result.scrolled,
        result.cursor_row == 5'(SCREEN_HEIGHT - 1), "scroll off bottom row")

    `CTS_ASSERT_NXT(a_set_cursor, clk, rst_n,
        start && !busy && (request.action == ACT_SET) &&
        (request.column <= 7'(SCREEN_WIDTH)) && (request.row <= 5'(SCREEN_HEIGHT - 1)),
        done && (result.cursor_column == $past(request.column)) &&
        (result.cursor_row == $past(request.row)), "set cursor mismatch")

endmodule

bind text_console_cursor_scroll cts_checker u_cts_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .request   (request),
    .done      (done),
    .result    (result)
);

// ===== tb/tb_text_console_cursor_scroll.sv =====
module tb_text_console_cursor_scroll;
    import cts_pkg::*;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    req_t       request;
    logic       done;
    res_t       result;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [3:0] cfg_data;

    // software copy of the console state
    logic [15:0] screen_copy [CELL_COUNT];
    int          cur_col;
    int          cur_row;
    logic [3:0]  dflt_color;

    res_t        cursor_reports [$];
    int          mismatch_count;
    bit          idling_on;

    text_console_cursor_scroll i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;

    always #5 clk = ~clk;

    initial
    begin
        #200_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic void shift_screen_up();
        for (int i = 0; i < CELL_COUNT; i++)
        begin
            if (i < CELL_COUNT - SCREEN_WIDTH)
                screen_copy[i] = screen_copy[i + SCREEN_WIDTH];
            else
                screen_copy[i] = 16'h0000;
        end
    endfunction

    function automatic void blank_screen();
        for (int i = 0; i < CELL_COUNT; i++)
            screen_copy[i] = 16'h0000;
        cur_col = 0;
        cur_row = 0;
    endfunction

    function automatic res_t console_apply(input req_t r);
        res_t       rep;
        logic [3:0] fg;
        rep = '0;
        case (r.action)
            ACT_PUT:
            begin
                fg = r.use_default_color ? dflt_color : r.color;
                if (r.char_code == CH_NEWLINE)
                begin
                    cur_row++;
                    cur_col = 0;
                end
                if (r.char_code == CH_RETURN)
                    cur_col = 0;
                if (cur_col >= SCREEN_WIDTH)
                begin
                    cur_col = 0;
                    cur_row++;
                end
                if (cur_row >= SCREEN_HEIGHT)
                begin
                    cur_row = SCREEN_HEIGHT - 1;
                    cur_col = 0;
                    shift_screen_up();
                    rep.scrolled = 1'b1;
                end
                if (r.char_code != CH_NEWLINE && r.char_code != CH_RETURN)
                begin
                    screen_copy[cur_row * SCREEN_WIDTH + cur_col] = {4'h0, fg, r.char_code};
                    cur_col++;
                end
            end
            ACT_SET:
            begin
                cur_col = (int'(r.column) > SCREEN_WIDTH) ? SCREEN_WIDTH : int'(r.column);
                cur_row = (int'(r.row) > SCREEN_HEIGHT - 1) ? SCREEN_HEIGHT - 1 : int'(r.row);
            end
            ACT_CLEAR:
                blank_screen();
            default:
            begin
                if (int'(r.column) < SCREEN_WIDTH && int'(r.row) < SCREEN_HEIGHT)
                    rep.cell_value = screen_copy[int'(r.row) * SCREEN_WIDTH + int'(r.column)];
            end
        endcase
        rep.cursor_column = 7'(cur_col);
        rep.cursor_row    = 5'(cur_row);
        return rep;
    endfunction

    function automatic req_t console_req(input action_t act, input logic [7:0] ch,
                                         input logic [3:0] fg, input logic use_dflt,
                                         input logic [6:0] x, input logic [4:0] y);
        req_t r;
        r.action            = act;
        r.char_code         = ch;
        r.color             = fg;
        r.use_default_color = use_dflt;
        r.column            = x;
        r.row               = y;
        return r;
    endfunction

    // mostly text near the bottom so that wraps and scrolls happen often
    function automatic req_t random_request();
        req_t r;
        int   pick;
        int   y;
        r.char_code         = 8'($urandom);
        r.color             = 4'($urandom);
        r.use_default_color = 1'($urandom);
        r.column            = 7'($urandom);
        r.row               = 5'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 55)
        begin
            r.action = ACT_PUT;
            pick = $urandom_range(0, 99);
            if (pick < 8)
                r.char_code = CH_NEWLINE;
            else if (pick < 12)
                r.char_code = CH_RETURN;
        end
        else if (pick < 72)
        begin
            r.action = ACT_SET;
            if ($urandom_range(0, 1) == 0)
            begin
                r.column = 7'($urandom_range(SCREEN_WIDTH - 6, SCREEN_WIDTH));
                r.row    = 5'($urandom_range(SCREEN_HEIGHT - 3, SCREEN_HEIGHT - 1));
            end
        end
        else if (pick < 98)
        begin
            r.action = ACT_READ;
            if ($urandom_range(0, 3) != 0)
            begin
                y = cur_row - int'($urandom_range(0, 2));
                if (y < 0)
                    y = 0;
                r.row    = 5'(y);
                r.column = 7'($urandom_range(0, SCREEN_WIDTH - 1));
            end
        end
        else
            r.action = ACT_CLEAR;
        return r;
    endfunction

    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && done)
        begin
            if (cursor_reports.size() == 0)
            begin
                $error("result with no request outstanding");
                mismatch_count++;
            end
            else
            begin
                want = cursor_reports.pop_front();
                if (result.cell_value !== want.cell_value)
                begin
                    $error("cell_value expected %h got %h", want.cell_value, result.cell_value);
                    mismatch_count++;
                end
                if (result.cursor_column !== want.cursor_column)
                begin
                    $error("cursor_column expected %0d got %0d",
                           want.cursor_column, result.cursor_column);
                    mismatch_count++;
                end
                if (result.cursor_row !== want.cursor_row)
                begin
                    $error("cursor_row expected %0d got %0d",
                           want.cursor_row, result.cursor_row);
                    mismatch_count++;
                end
                if (result.scrolled !== want.scrolled)
                begin
                    $error("scrolled expected %0d got %0d", want.scrolled, result.scrolled);
                    mismatch_count++;
                end
            end
        end
    end

    task automatic idle_sender(input int cycles);
        @(negedge clk);
        start <= 1'b0;
        repeat (cycles - 1)
            @(negedge clk);
    endtask

    task automatic send_request(input req_t r);
        @(negedge clk);
        start   <= 1'b1;
        request <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        cursor_reports.push_back(console_apply(r));
        if (idling_on && $urandom_range(0, 3) == 0)
            idle_sender($urandom_range(1, 8));
    endtask

    task automatic wait_drained();
        @(negedge clk);
        start <= 1'b0;
        while (cursor_reports.size() != 0 || busy)
            @(negedge clk);
    endtask

    task automatic write_default_color(input logic [3:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        dflt_color = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_directed_cases();
        send_request(console_req(ACT_PUT, 8'h41, 4'h2, 1'b0, 7'd0, 5'd0));
        send_request(console_req(ACT_PUT, 8'hFF, 4'hF, 1'b0, 7'd127, 5'd31));
        send_request(console_req(ACT_PUT, 8'h00, 4'h0, 1'b1, 7'd0, 5'd0));
        send_request(console_req(ACT_PUT, 8'h80, 4'h5, 1'b0, 7'd0, 5'd0));
        send_request(console_req(ACT_READ, 8'h00, 4'h0, 1'b0, 7'd0, 5'd0));
        send_request(console_req(ACT_READ, 8'hFF, 4'hF, 1'b1, 7'd1, 5'd0));
        send_request(console_req(ACT_READ, 8'h00, 4'h0, 1'b0, 7'd3, 5'd0));
        send_request(console_req(ACT_PUT, CH_RETURN, 4'h1, 1'b0, 7'd0, 5'd0));
        send_request(console_req(ACT_PUT, CH_NEWLINE, 4'h1, 1'b0, 7'd0, 5'd0));
        // saturating set lands on the pending wrap at the bottom
        send_request(console_req(ACT_SET, 8'h00, 4'h0, 1'b0, 7'd127, 5'd31));
        send_request(console_req(ACT_PUT, CH_RETURN, 4'h3, 1'b0, 7'd0, 5'd0));
        send_request(console_req(ACT_SET, 8'h00, 4'h0, 1'b0, 7'd79, 5'd24));
        send_request(console_req(ACT_PUT, 8'h58, 4'h0, 1'b0, 7'd0, 5'd0));
        // wrap at the right edge of the bottom line forces a scroll
        send_request(console_req(ACT_PUT, 8'h59, 4'hF, 1'b1, 7'd0, 5'd0));
        send_request(console_req(ACT_READ, 8'h00, 4'h0, 1'b0, 7'd79, 5'd23));
        send_request(console_req(ACT_READ, 8'h00, 4'h0, 1'b0, 7'd0, 5'd24));
        send_request(console_req(ACT_READ, 8'h00, 4'h0, 1'b0, 7'd80, 5'd0));
        send_request(console_req(ACT_READ, 8'h00, 4'h0, 1'b0, 7'd0, 5'd25));
        send_request(console_req(ACT_READ, 8'h00, 4'h0, 1'b0, 7'd127, 5'd31));
        // newline on the bottom line scrolls too
        send_request(console_req(ACT_SET, 8'h00, 4'h0, 1'b0, 7'd5, 5'd24));
        send_request(console_req(ACT_PUT, CH_NEWLINE, 4'h0, 1'b0, 7'd0, 5'd0));
        send_request(console_req(ACT_READ, 8'h00, 4'h0, 1'b0, 7'd79, 5'd22));
        send_request(console_req(ACT_SET, 8'h00, 4'h0, 1'b0, 7'd40, 5'd12));
        send_request(console_req(ACT_CLEAR, 8'hAA, 4'hA, 1'b1, 7'd85, 5'd21));
        send_request(console_req(ACT_READ, 8'h00, 4'h0, 1'b0, 7'd0, 5'd22));
    endtask

    task automatic test_color_phase(input logic [3:0] value, input int count);
        write_default_color(value);
        repeat (count)
            send_request(random_request());
    endtask

    task automatic test_back_to_back(input int count);
        write_default_color(4'($urandom));
        idling_on = 1'b0;
        repeat (count)
            send_request(random_request());
    endtask

    initial
    begin
        rst_n          = 1'b0;
        start          = 1'b0;
        request        = '0;
        cfg_valid      = 1'b0;
        cfg_data       = 4'h0;
        mismatch_count = 0;
        idling_on      = 1'b1;
        dflt_color     = 4'd7;
        blank_screen();
        repeat (8)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_cases();
        test_color_phase(4'hF, 300);
        test_color_phase(4'h0, 300);
        test_color_phase(4'($urandom), 300);
        test_back_to_back(300);

        wait_drained();
        repeat (50)
            @(posedge clk);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
